// ----- rtl/cqr_pkg.sv -----
// Shared types and constants for the circular queue with replace.
// Used by cqr_cell and circular_queue_with_replace; depends on nothing else.
package cqr_pkg;

    // Number of cells in the row, the largest capacity the queue can take.
    localparam int Depth = 16;
    // Width of a fill count that can hold 0 through Depth.
    localparam int CntW = $clog2(Depth + 1);
    // Widths fixed by the request and result fields.
    localparam int WordW = 32;
    localparam int FuncW = 2;
    localparam int StatW = 2;
    localparam int CapW  = 5;
    localparam logic [CapW-1:0] CapReset = CapW'(16);

    // Request kinds.
    localparam logic [FuncW-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FuncW-1:0] FUNC_REMOVE  = 2'd1;
    localparam logic [FuncW-1:0] FUNC_PEEK    = 2'd2;
    localparam logic [FuncW-1:0] FUNC_REPLACE = 2'd3;

    // Result status codes.
    localparam logic [StatW-1:0] STAT_OK        = 2'd0;
    localparam logic [StatW-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [StatW-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [StatW-1:0] STAT_NOT_FOUND = 2'd3;

    // Per-cell control: shift takes the neighbor's word, load takes the broadcast word.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// ----- rtl/cqr_cell.sv -----
// One storage cell of the queue row: holds one word, moves toward the head.
// Depends on cqr_pkg for the word width and the control struct.
module cqr_cell
    import cqr_pkg::*;
(
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic signed [WordW-1:0] load_word,
    input  logic signed [WordW-1:0] nbr_word,
    output logic signed [WordW-1:0] word
);

    logic signed [WordW-1:0] word_reg;
    logic signed [WordW-1:0] word_next;

    // A load wins over a shift; otherwise the cell holds its word.
    always_comb begin
        if (ctrl.load) begin
            word_next = load_word;
        end else if (ctrl.shift) begin
            word_next = nbr_word;
        end else begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- rtl/circular_queue_with_replace.sv -----
// Top level of the circular queue with replace: control, fill count and result register.
// Depends on cqr_pkg and instantiates one cqr_cell per queue slot.
//
// Usage:
// Requests arrive on the s_ channel (s_func, s_data_word, s_match_word) with
// s_valid/s_ready, and each gives exactly one result on the m_ channel
// (m_status, m_read_word) with m_valid/m_ready. The words live in a row of
// cells kept in queue order, with the head in cell 0.
// Insert, remove, peek and the empty and overflow error results appear in
// the cycle after the item is accepted. A replace on a non-empty queue
// rotates the live words once around the row, one cell per cycle, so its
// result appears in the cycle after the last walk step. The queue takes
// one item at a time: a new item is accepted once the previous one has
// finished and the result register is free or is being emptied in the same
// cycle, so insert, remove and peek items can follow one per cycle, and a
// stalled receiver holds the result and blocks further input.
// cfg_wen with cfg_wdata sets the capacity (0 acts as 1, above 16 acts as
// 16) and empties the queue. Reset empties the queue, sets the capacity to
// 16 and clears the result channel; the stored words are not cleared.
module circular_queue_with_replace
    import cqr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [CapW-1:0]         cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [FuncW-1:0]        s_func,
    input  logic signed [WordW-1:0] s_data_word,
    input  logic signed [WordW-1:0] s_match_word,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [StatW-1:0]        m_status,
    output logic signed [WordW-1:0] m_read_word
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                    state_reg, state_next;
    logic [CapW-1:0]         cap_reg, cap_next;
    logic [CntW-1:0]         count_reg, count_next;
    logic [CntW-1:0]         steps_reg, steps_next;
    logic                    found_reg, found_next;
    logic signed [WordW-1:0] new_word_reg, new_word_next;
    logic signed [WordW-1:0] match_reg, match_next;
    logic                    m_valid_reg, m_valid_next;
    logic [StatW-1:0]        status_reg, status_next;
    logic signed [WordW-1:0] read_reg, read_next;

    logic [CntW-1:0]         cap_eff;
    logic                    accept;
    logic                    hit;
    logic signed [WordW-1:0] wrap_word;
    logic                    shift_all;
    logic                    load_en;
    logic [CntW-1:0]         load_pos;
    logic signed [WordW-1:0] load_word;
    logic signed [WordW-1:0] cell_word [Depth];

    // Capacity in use: the register clamped to one through Depth.
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CntW'(1);
        end else if (32'(cap_reg) > 32'(Depth)) begin
            cap_eff = CntW'(Depth);
        end else begin
            cap_eff = CntW'(cap_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Walk step: compare the head word, send it (or its replacement) to the tail.
    assign hit       = !found_reg && (cell_word[0] == match_reg);
    assign wrap_word = hit ? new_word_reg : cell_word[0];

    // Sequencer, fill count and result register.
    always_comb begin
        state_next    = state_reg;
        cap_next      = cap_reg;
        count_next    = count_reg;
        steps_next    = steps_reg;
        found_next    = found_reg;
        new_word_next = new_word_reg;
        match_next    = match_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        status_next   = status_reg;
        read_next     = read_reg;
        shift_all     = 1'b0;
        load_en       = 1'b0;
        load_pos      = count_reg;
        load_word     = s_data_word;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    status_next  = STAT_OK;
                    read_next    = '0;
                    case (s_func)
                        FUNC_INSERT: begin
                            if (count_reg == cap_eff) begin
                                status_next = STAT_OVERFLOW;
                            end else begin
                                load_en    = 1'b1;
                                count_next = count_reg + CntW'(1);
                            end
                        end
                        FUNC_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                read_next  = cell_word[0];
                                shift_all  = 1'b1;
                                count_next = count_reg - CntW'(1);
                            end
                        end
                        FUNC_PEEK: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                read_next = cell_word[0];
                            end
                        end
                        FUNC_REPLACE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                m_valid_next  = 1'b0;
                                state_next    = ST_WALK;
                                steps_next    = count_reg;
                                found_next    = 1'b0;
                                new_word_next = s_data_word;
                                match_next    = s_match_word;
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // Rotate the live words by one; after count steps the order is restored.
                shift_all  = 1'b1;
                load_en    = 1'b1;
                load_pos   = count_reg - CntW'(1);
                load_word  = wrap_word;
                found_next = found_reg || hit;
                steps_next = steps_reg - CntW'(1);
                if (steps_reg == CntW'(1)) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    status_next  = (found_reg || hit) ? STAT_OK : STAT_NOT_FOUND;
                    read_next    = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A capacity write empties the queue.
        if (cfg_wen) begin
            cap_next   = cfg_wdata;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CapReset;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg    <= steps_next;
        found_reg    <= found_next;
        new_word_reg <= new_word_next;
        match_reg    <= match_next;
        status_reg   <= status_next;
        read_reg     <= read_next;
    end

    // Row of cells; cell i takes its word from cell i+1 on a shift.
    genvar gi;
    generate
        for (gi = 0; gi < Depth; gi++) begin : g_cell
            cell_ctrl_t              ctrl;
            logic signed [WordW-1:0] nbr;

            assign ctrl.shift = shift_all;
            assign ctrl.load  = load_en && (load_pos == CntW'(gi));

            if (gi < Depth - 1) begin : g_mid
                assign nbr = cell_word[gi+1];
            end else begin : g_last
                assign nbr = '0;
            end

            cqr_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .load_word (load_word),
                .nbr_word  (nbr),
                .word      (cell_word[gi])
            );
        end
    endgenerate

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_read_word = read_reg;

    // The fill count never exceeds the capacity in use.
    a_count_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_eff)
        else $error("fill count above capacity");

    // No new item is taken while a replace walk is running.
    a_no_accept_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> !s_ready)
        else $error("input ready during walk");

    // The result register stays empty until the walk delivers its result.
    a_no_result_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> !m_valid_reg)
        else $error("result pending during walk");

    // A successful insert grows the count by one.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_func == FUNC_INSERT) && (count_reg != cap_eff) && !cfg_wen)
        |=> (count_reg == $past(count_reg) + CntW'(1)))
        else $error("insert did not grow the count");

    // A walk never outlasts the number of live words.
    a_walk_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> ((steps_reg != '0) && (steps_reg <= count_reg)))
        else $error("walk step counter out of range");

endmodule

// ----- tb/sv/circular_queue_with_replace_tb.sv -----
// Self-checking testbench for circular_queue_with_replace: directed and random request items.
// It keeps its own model of the queue to predict every result item.
// Depends on cqr_pkg and the circular_queue_with_replace RTL.
module circular_queue_with_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cqr_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_CYCLES = 300;
    localparam int PHASE_ITEMS  = 80;
    localparam int CYCLE_LIMIT  = 400000;

    // One result item as the queue returns it.
    typedef struct packed {
        logic [StatW-1:0]        status;
        logic signed [WordW-1:0] read_word;
    } queue_result_t;

    // Directed rows either carry a typed-in result, rely on the model, or set the capacity.
    typedef enum logic [1:0] {ROW_CHECKED, ROW_PREDICTED, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CapW-1:0]  cap;
        logic [FuncW-1:0] func;
        logic [WordW-1:0] data_word;
        logic [WordW-1:0] match_word;
        logic [StatW-1:0] status;
        logic [WordW-1:0] read_word;
    } plan_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [CapW-1:0]         cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [FuncW-1:0]        s_func = FUNC_INSERT;
    logic signed [WordW-1:0] s_data_word = '0;
    logic signed [WordW-1:0] s_match_word = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [StatW-1:0]        m_status;
    logic signed [WordW-1:0] m_read_word;

    // Model of the queue: slots, pointers, empty flag and the capacity register.
    logic [WordW-1:0] mirror_slots [0:Depth-1];
    int               mirror_head;
    int               mirror_tail;
    bit               mirror_empty;
    logic [CapW-1:0]  mirror_cap;

    queue_result_t pending_results [$];
    int            errors = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            stall_asks = 0;
    int            stall_seen = 0;
    int            hold_left = 0;

    // Capacities of the random phases, extremes included.
    logic [CapW-1:0] phase_caps [0:5] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd9};

    // Directed items: empty errors, word extremes, replace hit and miss, overflow,
    // capacity clamping at both ends, and the queue emptied by a capacity write.
    plan_row_t plan [0:23] = '{
        '{ROW_CHECKED,   5'd0,  FUNC_REMOVE,  32'h0,        32'h0,        STAT_EMPTY,    32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_PEEK,    32'h0,        32'h0,        STAT_EMPTY,    32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_REPLACE, 32'h1,        32'h0,        STAT_EMPTY,    32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_INSERT,  32'h7FFFFFFF, 32'h0,        STAT_OK,       32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_INSERT,  32'h80000000, 32'hFFFFFFFF, STAT_OK,       32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_INSERT,  32'hFFFFFFFF, 32'h0,        STAT_OK,       32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_PEEK,    32'h0,        32'h0,        STAT_OK,       32'h7FFFFFFF},
        '{ROW_CHECKED,   5'd0,  FUNC_REPLACE, 32'h0,        32'h12345678, STAT_NOT_FOUND, 32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_REPLACE, 32'h55555555, 32'h80000000, STAT_OK,       32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_REPLACE, 32'hAAAAAAAA, 32'hFFFFFFFF, STAT_OK,       32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_REMOVE,  32'h0,        32'h0,        STAT_OK,       32'h7FFFFFFF},
        '{ROW_PREDICTED, 5'd0,  FUNC_REMOVE,  32'h0,        32'h0,        STAT_OK,       32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_REMOVE,  32'h0,        32'h0,        STAT_OK,       32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_REMOVE,  32'h0,        32'h0,        STAT_EMPTY,    32'h0},
        '{ROW_CONFIG,    5'd0,  FUNC_INSERT,  32'h0,        32'h0,        STAT_OK,       32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_INSERT,  32'h13579BDF, 32'h0,        STAT_OK,       32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_INSERT,  32'h2468ACE0, 32'h0,        STAT_OVERFLOW, 32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_REPLACE, 32'h0,        32'h13579BDF, STAT_OK,       32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_PEEK,    32'h0,        32'h0,        STAT_OK,       32'h0},
        '{ROW_CONFIG,    5'd31, FUNC_INSERT,  32'h0,        32'h0,        STAT_OK,       32'h0},
        '{ROW_CHECKED,   5'd0,  FUNC_PEEK,    32'h0,        32'h0,        STAT_EMPTY,    32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_INSERT,  32'h1,        32'h0,        STAT_OK,       32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_INSERT,  32'h2,        32'h0,        STAT_OK,       32'h0},
        '{ROW_PREDICTED, 5'd0,  FUNC_REMOVE,  32'h0,        32'h0,        STAT_OK,       32'h0}
    };

    circular_queue_with_replace dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_data_word (s_data_word),
        .s_match_word(s_match_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_word (m_read_word)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The register is clamped to 1 through Depth before use.
    function automatic int cap_in_use();
        if (mirror_cap == 0) begin
            return 1;
        end
        if (mirror_cap > Depth) begin
            return Depth;
        end
        return int'(mirror_cap);
    endfunction

    function automatic int advance(input int idx);
        return (idx + 1 >= cap_in_use()) ? 0 : idx + 1;
    endfunction

    function automatic int live_count();
        if (mirror_empty) begin
            return 0;
        end
        if (mirror_head == mirror_tail) begin
            return cap_in_use();
        end
        return (mirror_tail + cap_in_use() - mirror_head) % cap_in_use();
    endfunction

    // Applies one request item to the model and returns the result item it causes.
    function automatic queue_result_t queue_response(input logic [FuncW-1:0] func,
                                                     input logic [WordW-1:0] data_word,
                                                     input logic [WordW-1:0] match_word);
        queue_result_t res;
        int            walk;
        int            idx;
        bit            found;
        res.status = STAT_OK;
        res.read_word = '0;
        if (func == FUNC_INSERT) begin
            if (!mirror_empty && mirror_head == mirror_tail) begin
                res.status = STAT_OVERFLOW;
            end else begin
                mirror_slots[mirror_tail] = data_word;
                mirror_tail = advance(mirror_tail);
                mirror_empty = 1'b0;
            end
        end else if (mirror_empty) begin
            res.status = STAT_EMPTY;
        end else if (func == FUNC_REMOVE) begin
            res.read_word = mirror_slots[mirror_head];
            mirror_head = advance(mirror_head);
            if (mirror_head == mirror_tail) begin
                mirror_empty = 1'b1;
            end
        end else if (func == FUNC_PEEK) begin
            res.read_word = mirror_slots[mirror_head];
        end else begin
            // Replace overwrites only the first live word that matches, head first.
            walk = live_count();
            idx = mirror_head;
            found = 1'b0;
            for (int k = 0; k < walk; k++) begin
                if (!found && mirror_slots[idx] == match_word) begin
                    mirror_slots[idx] = data_word;
                    found = 1'b1;
                end
                idx = advance(idx);
            end
            res.status = found ? STAT_OK : STAT_NOT_FOUND;
        end
        return res;
    endfunction

    // A few recurring words so that replace finds duplicates and extremes.
    function automatic logic [WordW-1:0] pool_word(input int sel);
        case (sel)
            0: begin
                return 32'h0;
            end
            1: begin
                return 32'h1;
            end
            2: begin
                return 32'hFFFFFFFF;
            end
            3: begin
                return 32'h7FFFFFFF;
            end
            4: begin
                return 32'h80000000;
            end
            default: begin
                return 32'h000000A5;
            end
        endcase
    endfunction

    // Offers one request item, waits for it to be taken and queues its expected result.
    task automatic offer_request(input logic [FuncW-1:0] func, input logic [WordW-1:0] data_word,
                                 input logic [WordW-1:0] match_word, input bit typed,
                                 input queue_result_t typed_result);
        queue_result_t modeled;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_data_word <= data_word;
        s_match_word <= match_word;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        modeled = queue_response(func, data_word, match_word);
        pending_results.push_back(typed ? typed_result : modeled);
    endtask

    // Waits until every expected result has arrived and the block has gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Capacity writes happen only on an idle block; they also empty the queue.
    task automatic write_capacity(input logic [CapW-1:0] value);
        settle();
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        mirror_cap = value;
        mirror_head = 0;
        mirror_tail = 0;
        mirror_empty = 1'b1;
    endtask

    // Result side: random or held-off ready, and a check of each accepted result item.
    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result item, status %0d word %h",
                             $time, m_status, m_read_word);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                    if (m_read_word !== want.read_word) begin
                        $display("%0t: read_word mismatch, expected %h, actual %h",
                                 $time, want.read_word, m_read_word);
                        errors++;
                    end
                end
            end
            if (stall_asks != stall_seen) begin
                stall_seen = stall_asks;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then random phases over several capacities.
    initial begin
        logic [FuncW-1:0] func;
        logic [WordW-1:0] data_word;
        logic [WordW-1:0] match_word;
        int               insert_pct;
        int               live;
        int               pick;
        mirror_cap = CapReset;
        mirror_head = 0;
        mirror_tail = 0;
        mirror_empty = 1'b1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 74;
        for (int r = 0; r < $size(plan); r++) begin
            if (plan[r].kind == ROW_CONFIG) begin
                write_capacity(plan[r].cap);
            end else begin
                offer_request(plan[r].func, plan[r].data_word, plan[r].match_word,
                              plan[r].kind == ROW_CHECKED,
                              queue_result_t'{plan[r].status, plan[r].read_word});
            end
        end

        for (int p = 0; p < $size(phase_caps); p++) begin
            write_capacity(phase_caps[p]);
            // Sender-light then receiver-light idling, and the last phases without gaps.
            case (p / 2)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            insert_pct = (p == 0) ? 60 : ((p % 2) != 0 ? 30 : 45);
            // Hold the receiver off long enough for the block to back up its input.
            if (p == 0) begin
                stall_asks++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < insert_pct) begin
                    func = FUNC_INSERT;
                end else begin
                    pick = $urandom_range(9);
                    func = (pick < 4) ? FUNC_REMOVE : ((pick < 6) ? FUNC_PEEK : FUNC_REPLACE);
                end
                data_word = ($urandom_range(3) == 0) ? pool_word($urandom_range(5)) : $urandom();
                // Mostly search for a word that is live, so replace often hits.
                live = live_count();
                if (live > 0 && $urandom_range(9) < 6) begin
                    match_word = mirror_slots[(mirror_head + $urandom_range(live - 1))
                                              % cap_in_use()];
                end else begin
                    match_word = ($urandom_range(1) == 0) ? pool_word($urandom_range(5))
                                                          : $urandom();
                end
                offer_request(func, data_word, match_word, 1'b0, '0);
            end
        end

        settle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cqr_pkg.sv
rtl/cqr_cell.sv
rtl/circular_queue_with_replace.sv
tb/sv/circular_queue_with_replace_tb.sv
